// ===== rtl/ide_pkg.sv =====
`default_nettype none

package ide_pkg;

  // Store size and field widths.
  localparam int unsigned CAPACITY = 16;
  localparam int unsigned ADDR_W   = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = 5;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned OP_W     = 4;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned STS_W    = 2;

  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [ADDR_W-1:0] addr_t;

  localparam cnt_t CAP_CNT = cnt_t'(CAPACITY);

  // Operation codes of an input beat.
  typedef enum logic [OP_W-1:0] {
    OP_PUSH_BACK  = 4'd0,
    OP_PUSH_FRONT = 4'd1,
    OP_POP_FRONT  = 4'd2,
    OP_POP_BACK   = 4'd3,
    OP_PEEK_BACK  = 4'd4,
    OP_PEEK_FRONT = 4'd5,
    OP_READ_AT    = 4'd6,
    OP_INSERT_AT  = 4'd7,
    OP_REMOVE_AT  = 4'd8,
    OP_CLEAR      = 4'd9,
    OP_SORT_ASC   = 4'd10,
    OP_SORT_DESC  = 4'd11
  } op_e;

  // Result status codes.
  typedef enum logic [STS_W-1:0] {
    STS_OK   = 2'd0,
    STS_BAD  = 2'd1,
    STS_FULL = 2'd2
  } status_e;

  // Source of the store write data.
  typedef enum logic [1:0] {
    WSEL_ITEM,
    WSEL_RDATA,
    WSEL_CUR
  } wsel_e;

  // Update of the entry count.
  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC,
    CNT_CLR
  } cnt_op_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    item_load;
    logic    res_clr;
    logic    res_load;
    logic    rd_en;
    addr_t   rd_addr;
    logic    wr_en;
    addr_t   wr_addr;
    wsel_e   wr_sel;
    logic    cur_load;
    cnt_op_e cnt_op;
    logic    out_load;
    status_e out_status;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    cnt_t count;
    logic cur_gt;
    logic cur_lt;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== rtl/ide_req_if.sv =====
`default_nettype none

interface ide_req_if;
  import ide_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          operation;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] item_value;

  modport source (output valid, output operation, output position, output item_value,
                  input ready);
  modport sink (input valid, input operation, input position, input item_value,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/ide_rsp_if.sv =====
`default_nettype none

interface ide_rsp_if;
  import ide_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] result_value;
  logic [STS_W-1:0]         status;
  logic [CNT_W-1:0]         entry_count;

  modport source (output valid, output result_value, output status, output entry_count,
                  input ready);
  modport sink (input valid, input result_value, input status, input entry_count,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/ide_dpath.sv =====
`default_nettype none

module ide_dpath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  ide_pkg::dp_cmd_t                 cmd_i,
  input  logic signed [ide_pkg::DATA_W-1:0] item_value_i,
  output ide_pkg::dp_sts_t                 sts_o,
  output logic signed [ide_pkg::DATA_W-1:0] result_value_o,
  output logic [ide_pkg::STS_W-1:0]        status_o,
  output logic [ide_pkg::CNT_W-1:0]        entry_count_o
);
  import ide_pkg::*;

  logic signed [DATA_W-1:0] store_q [CAPACITY];
  logic signed [DATA_W-1:0] rd_data_q;
  logic signed [DATA_W-1:0] cur_q;
  logic signed [DATA_W-1:0] item_q;
  logic signed [DATA_W-1:0] res_q;
  logic signed [DATA_W-1:0] wr_data;
  logic signed [DATA_W-1:0] out_value_q;
  status_e                  out_status_q;
  cnt_t                     out_count_q;
  cnt_t                     cnt_q;
  cnt_t                     cnt_d;

  // Write data selection for the store.
  always_comb begin
    case (cmd_i.wr_sel)
      WSEL_ITEM:  wr_data = item_q;
      WSEL_RDATA: wr_data = rd_data_q;
      WSEL_CUR:   wr_data = cur_q;
      default:    wr_data = item_q;
    endcase
  end

  // Next entry count.
  always_comb begin
    case (cmd_i.cnt_op)
      CNT_INC: cnt_d = cnt_q + cnt_t'(1);
      CNT_DEC: cnt_d = cnt_q - cnt_t'(1);
      CNT_CLR: cnt_d = '0;
      default: cnt_d = cnt_q;
    endcase
  end

  // The entry count is the only control state here.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Store with one write and one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      store_q[cmd_i.wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= store_q[cmd_i.rd_addr];
    end
  end

  // Payload registers: input value, carried sort value, result and output beat.
  always_ff @(posedge clk_i) begin
    if (cmd_i.item_load) begin
      item_q <= item_value_i;
    end
    if (cmd_i.cur_load) begin
      cur_q <= rd_data_q;
    end
    if (cmd_i.res_clr) begin
      res_q <= '0;
    end else if (cmd_i.res_load) begin
      res_q <= rd_data_q;
    end
    if (cmd_i.out_load) begin
      out_value_q  <= res_q;
      out_status_q <= cmd_i.out_status;
      out_count_q  <= cnt_q;
    end
  end

  // Signed comparison of the carried value with the entry just read.
  assign sts_o.count  = cnt_q;
  assign sts_o.cur_gt = (cur_q > rd_data_q);
  assign sts_o.cur_lt = (cur_q < rd_data_q);

  assign result_value_o = out_value_q;
  assign status_o       = out_status_q;
  assign entry_count_o  = out_count_q;

endmodule

`default_nettype wire

// ===== rtl/ide_ctrl.sv =====
`default_nettype none

module ide_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [ide_pkg::OP_W-1:0]   operation_i,
  input  logic [ide_pkg::POS_W-1:0]  position_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  input  ide_pkg::dp_sts_t           sts_i,
  output ide_pkg::dp_cmd_t           cmd_o
);
  import ide_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_WAIT,
    S_SH_RD,
    S_SH_WR,
    S_INS_RD,
    S_INS_WR,
    S_INS_PUT,
    S_SORT_LD,
    S_SORT_LDW,
    S_SORT_RD,
    S_SORT_CMP,
    S_RESP
  } state_e;

  state_e  state_q, state_d;
  op_e     op_q, op_d;
  cnt_t    tgt_q, tgt_d;
  cnt_t    ptr_q, ptr_d;
  logic    swapped_q, swapped_d;
  status_e st_q, st_d;
  logic    out_valid_q, out_valid_d;

  op_e     in_op;
  cnt_t    count;
  cnt_t    pos;
  cnt_t    ins_idx;
  cnt_t    rd_idx;
  logic    rd_bad;
  cnt_t    ptr_nx;
  cnt_t    ptr_pv;
  cnt_t    last_idx;
  logic    swap;

  assign in_op    = op_e'(operation_i);
  assign count    = sts_i.count;
  assign pos      = cnt_t'(position_i);
  assign ptr_nx   = ptr_q + cnt_t'(1);
  assign ptr_pv   = ptr_q - cnt_t'(1);
  assign last_idx = count - cnt_t'(1);
  assign swap     = (op_q == OP_SORT_DESC) ? sts_i.cur_lt : sts_i.cur_gt;

  // Index decode of the incoming beat.
  always_comb begin
    if (in_op == OP_PUSH_BACK) begin
      ins_idx = count;
    end else if (in_op == OP_PUSH_FRONT) begin
      ins_idx = '0;
    end else begin
      ins_idx = pos;
    end
    if (in_op inside {OP_POP_FRONT, OP_PEEK_FRONT}) begin
      rd_idx = '0;
      rd_bad = (count == '0);
    end else if (in_op inside {OP_POP_BACK, OP_PEEK_BACK}) begin
      rd_idx = last_idx;
      rd_bad = (count == '0);
    end else begin
      rd_idx = pos;
      rd_bad = (pos >= count);
    end
  end

  // Sequencer: next state and datapath commands.
  always_comb begin
    cmd_o            = '0;
    cmd_o.wr_sel     = WSEL_ITEM;
    cmd_o.cnt_op     = CNT_HOLD;
    cmd_o.out_status = st_q;
    state_d          = state_q;
    op_d             = op_q;
    tgt_d            = tgt_q;
    ptr_d            = ptr_q;
    swapped_d        = swapped_q;
    st_d             = st_q;
    out_valid_d      = out_valid_q && !out_ready_i;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.item_load = 1'b1;
          cmd_o.res_clr   = 1'b1;
          op_d            = in_op;
          st_d            = STS_OK;
          state_d         = S_RESP;
          case (in_op)
            OP_PUSH_BACK, OP_PUSH_FRONT, OP_INSERT_AT: begin
              if (in_op == OP_INSERT_AT && pos != '0 && pos > count) begin
                st_d = STS_BAD;
              end else if (count >= CAP_CNT) begin
                st_d = STS_FULL;
              end else begin
                tgt_d   = ins_idx;
                ptr_d   = count;
                state_d = S_INS_RD;
              end
            end
            OP_POP_FRONT, OP_POP_BACK, OP_PEEK_BACK, OP_PEEK_FRONT,
            OP_READ_AT, OP_REMOVE_AT: begin
              if (rd_bad) begin
                st_d = STS_BAD;
              end else begin
                cmd_o.rd_en   = 1'b1;
                cmd_o.rd_addr = rd_idx[ADDR_W-1:0];
                ptr_d         = rd_idx;
                state_d       = S_RD_WAIT;
              end
            end
            OP_CLEAR: begin
              cmd_o.cnt_op = CNT_CLR;
            end
            OP_SORT_ASC, OP_SORT_DESC: begin
              if (count == '0) begin
                st_d = STS_BAD;
              end else begin
                swapped_d = 1'b0;
                state_d   = S_SORT_LD;
              end
            end
            default: begin
              st_d = STS_BAD;
            end
          endcase
        end
      end

      // Read data is back: keep it as the result.
      S_RD_WAIT: begin
        cmd_o.res_load = 1'b1;
        if (op_q inside {OP_POP_FRONT, OP_POP_BACK, OP_REMOVE_AT}) begin
          state_d = S_SH_RD;
        end else begin
          state_d = S_RESP;
        end
      end

      // Removal: move the later entries down by one place.
      S_SH_RD: begin
        if (ptr_nx < count) begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_addr = ptr_nx[ADDR_W-1:0];
          state_d       = S_SH_WR;
        end else begin
          cmd_o.cnt_op = CNT_DEC;
          state_d      = S_RESP;
        end
      end
      S_SH_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = ptr_q[ADDR_W-1:0];
        cmd_o.wr_sel  = WSEL_RDATA;
        ptr_d         = ptr_nx;
        state_d       = S_SH_RD;
      end

      // Insertion: move entries up from the back, then place the new value.
      S_INS_RD: begin
        if (ptr_q > tgt_q) begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_addr = ptr_pv[ADDR_W-1:0];
          state_d       = S_INS_WR;
        end else begin
          state_d = S_INS_PUT;
        end
      end
      S_INS_WR: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = ptr_q[ADDR_W-1:0];
        cmd_o.wr_sel  = WSEL_RDATA;
        ptr_d         = ptr_pv;
        state_d       = S_INS_RD;
      end
      S_INS_PUT: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = tgt_q[ADDR_W-1:0];
        cmd_o.wr_sel  = WSEL_ITEM;
        cmd_o.cnt_op  = CNT_INC;
        state_d       = S_RESP;
      end

      // Bubble pass: carry the larger (or smaller) value towards the back.
      S_SORT_LD: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_addr = '0;
        ptr_d         = cnt_t'(1);
        state_d       = S_SORT_LDW;
      end
      S_SORT_LDW: begin
        cmd_o.cur_load = 1'b1;
        state_d        = S_SORT_RD;
      end
      S_SORT_RD: begin
        if (ptr_q < count) begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_addr = ptr_q[ADDR_W-1:0];
          state_d       = S_SORT_CMP;
        end else begin
          cmd_o.wr_en   = 1'b1;
          cmd_o.wr_addr = last_idx[ADDR_W-1:0];
          cmd_o.wr_sel  = WSEL_CUR;
          if (swapped_q) begin
            swapped_d = 1'b0;
            state_d   = S_SORT_LD;
          end else begin
            state_d = S_RESP;
          end
        end
      end
      S_SORT_CMP: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = ptr_pv[ADDR_W-1:0];
        if (swap) begin
          cmd_o.wr_sel = WSEL_RDATA;
          swapped_d    = 1'b1;
        end else begin
          cmd_o.wr_sel   = WSEL_CUR;
          cmd_o.cur_load = 1'b1;
        end
        ptr_d   = ptr_nx;
        state_d = S_SORT_RD;
      end

      // Hand the result to the output register once it is free.
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_PUSH_BACK;
      tgt_q       <= '0;
      ptr_q       <= '0;
      swapped_q   <= 1'b0;
      st_q        <= STS_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      tgt_q       <= tgt_d;
      ptr_q       <= ptr_d;
      swapped_q   <= swapped_d;
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  // The count never goes beyond the store size.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= CAP_CNT)
    else $error("entry count above capacity");

  // A read and a write never target the same entry in one cycle.
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.rd_en && cmd_o.wr_en) |-> (cmd_o.rd_addr != cmd_o.wr_addr))
    else $error("read and write to the same entry");

  // After an accepted beat no further beat is taken in the next cycle.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second beat accepted while busy");

  // A full status is only reported with a full store.
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.out_load && st_q == STS_FULL) |-> (count == CAP_CNT))
    else $error("full status with room left");

  // The sort comparison always sits inside the stored entries.
  a_sort_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SORT_CMP) |-> (ptr_q != '0 && ptr_q < count))
    else $error("sort index out of range");
`endif

endmodule

`default_nettype wire

// ===== rtl/indexed_deque_engine.sv =====
// From accepted beat to result beat: clear and any rejected beat go straight to the result,
// peek and read wait for one store read, push back places the value without moving entries,
// push front, insert and remove move entries one at a time through the one read port of the
// store, and a sort repeats bubble passes until one makes no swap; a stalled result beat waits.
// One operation is in flight at a time; the next beat is taken once the result sits in
// the output register. Reset clears the count and the control state; no clearing pass.
`default_nettype none

module indexed_deque_engine (
  input  logic   clk_i,
  input  logic   rst_ni,
  ide_req_if.sink   req_i,
  ide_rsp_if.source rsp_o
);
  import ide_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Operation sequencer.
  ide_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .operation_i (req_i.operation),
    .position_i  (req_i.position),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Store, count and result registers.
  ide_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .item_value_i   (req_i.item_value),
    .sts_o          (sts),
    .result_value_o (rsp_o.result_value),
    .status_o       (rsp_o.status),
    .entry_count_o  (rsp_o.entry_count)
  );

endmodule

`default_nettype wire
